@@ sv/bafl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bafl_pkg: shared definitions for the bump allocator with exact-fit free list
// Sizes, widths, result codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bafl_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int FREE_SLOTS = 64;
    localparam int HDR_BYTES  = 8;
    localparam int MIN_CHUNK  = 24;
    localparam int OFF_W      = 16;
    localparam int REQ_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int OFF_MAX    = 65535;

    localparam int HDR_DEPTH  = HEAP_BYTES / HDR_BYTES;
    localparam int HDR_AW     = $clog2(HDR_DEPTH);
    localparam int BUMP_W     = $clog2(HEAP_BYTES + 1);
    localparam int SIZE_W     = BUMP_W;
    localparam int SLOT_AW    = $clog2(FREE_SLOTS);
    localparam int CNT_W      = $clog2(FREE_SLOTS + 1);

    typedef enum logic [STATUS_W-1:0] {
        RES_REUSED     = 3'd0,
        RES_NEW        = 3'd1,
        RES_NO_SPACE   = 3'd2,
        RES_FREED      = 3'd3,
        RES_TABLE_FULL = 3'd4
    } res_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_BUMP,
        S_FREE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic load_req;
        logic set_no_space;
        logic scan_init;
        logic scan_rd;
        logic scan_dec;
        logic take_match;
        logic sh_rd;
        logic sh_wr;
        logic pop;
        logic bump;
        logic hdr_rd;
        logic push;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic oversize;
        logic cnt_zero;
        logic match;
        logic scan_zero;
        logic match_last;
        logic sh_last;
        logic out_free;
    } stat_t;

    function automatic logic [HDR_AW-1:0] hdr_index(input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] base;
        base = off - OFF_W'(HDR_BYTES);
        return HDR_AW'(32'(base) >> 3);
    endfunction

    function automatic logic hdr_in_range(input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] base;
        base = off - OFF_W'(HDR_BYTES);
        return (32'(base) >> 3) < 32'(HDR_DEPTH);
    endfunction

endpackage
`default_nettype wire

@@ sv/bump_allocator_exact_fit_free_list_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bump_allocator_exact_fit_free_list_core: heap allocator with a bump pointer
// and an exact-fit LIFO free table.
// Requests enter on the req channel (req_valid, req_stall): req_type selects
// allocate or free, req_size gives the payload bytes to allocate and
// free_offset the payload offset to free. Every request yields exactly one
// item on the rsp channel (rsp_valid, rsp_stall) carrying status and
// payload_offset. One request is processed at a time.
// An oversize allocate passes from decode straight to the output register,
// a free through S_FREE and a carve while the free table is empty through
// S_BUMP. Otherwise the free table is scanned from its top, each entry read
// in S_SCAN and compared in S_CMP: a reuse closes the gap by moving the
// entries above it down one at a time (S_SH_RD, S_SH_WR), and a fruitless
// scan ends in a carve through S_BUMP. A further request is accepted in the
// cycle after its predecessor's result enters the output register.
// Reset clears the bump pointer, the free table count and the output
// valid flag; the memories need no clearing. While rsp_stall is high the
// result is held, and a finished result waits until the register frees.
// ----------------------------------------------------------------------------
module bump_allocator_exact_fit_free_list_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          req_type,
    input  wire logic [bafl_pkg::REQ_W-1:0]    req_size,
    input  wire logic [bafl_pkg::OFF_W-1:0]    free_offset,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [bafl_pkg::STATUS_W-1:0]      status,
    output logic [bafl_pkg::OFF_W-1:0]         payload_offset
);
    import bafl_pkg::*;

    cmd_t  cmd;
    stat_t st;

    bafl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    bafl_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req_type),
        .req_size       (req_size),
        .free_offset    (free_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .payload_offset (payload_offset),
        .cmd            (cmd),
        .st             (st)
    );

endmodule
`default_nettype wire

@@ sv/bafl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bafl_ctrl: request sequencer
// Steps each request through decode, free table scan, entry removal, bump
// carving or free push, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bafl_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bafl_pkg::stat_t st,
    output bafl_pkg::cmd_t      cmd
);
    import bafl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.is_free)
                begin
                    cmd.hdr_rd = 1'b1;
                    state_next = S_FREE;
                end
                else if (st.oversize)
                begin
                    cmd.set_no_space = 1'b1;
                    state_next       = S_OUT;
                end
                else if (st.cnt_zero)
                begin
                    state_next = S_BUMP;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (st.match)
                begin
                    cmd.take_match = 1'b1;
                    if (st.match_last)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (st.scan_zero)
                begin
                    state_next = S_BUMP;
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SH_RD:
            begin
                cmd.sh_rd  = 1'b1;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.sh_wr = 1'b1;
                if (st.sh_last)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = S_OUT;
            end
            S_FREE:
            begin
                cmd.push   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/bafl_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bafl_dpath: allocator datapath
// Holds the bump pointer, the free table memory with its fill count, the
// chunk size header memory, the request and result registers and the output
// register.
// ----------------------------------------------------------------------------
module bafl_dpath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_type,
    input  wire logic [bafl_pkg::REQ_W-1:0]    req_size,
    input  wire logic [bafl_pkg::OFF_W-1:0]    free_offset,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [bafl_pkg::STATUS_W-1:0]      status,
    output logic [bafl_pkg::OFF_W-1:0]         payload_offset,
    input  wire bafl_pkg::cmd_t                cmd,
    output bafl_pkg::stat_t                    st
);
    import bafl_pkg::*;

    entry_t            table_mem [FREE_SLOTS];
    logic [SIZE_W-1:0] hdr_mem [HDR_DEPTH];

    logic [BUMP_W-1:0]  bump_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;

    logic               is_free_reg;
    logic               oversize_reg;
    logic [SIZE_W-1:0]  sz_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [SLOT_AW-1:0] scan_reg;
    logic [SLOT_AW-1:0] j_reg;
    entry_t             rdata_reg;
    logic [SIZE_W-1:0]  hdr_rdata_reg;
    logic               hdr_ok_reg;
    res_code_t          res_code_reg;
    logic [OFF_W-1:0]   res_pay_reg;
    res_code_t          out_code_reg;
    logic [OFF_W-1:0]   out_pay_reg;

    logic [REQ_W:0]     sum_w;
    logic [REQ_W:0]     rnd_w;
    logic [REQ_W:0]     rnd_min_w;
    logic               oversize_w;
    logic [BUMP_W:0]    end_w;
    logic [BUMP_W:0]    pay_w;
    logic               bump_fail;
    logic               tbl_we;
    logic [SLOT_AW-1:0] tbl_waddr;
    entry_t             tbl_wdata;
    logic [SLOT_AW-1:0] tbl_raddr;
    logic               tbl_re;
    logic               table_full;
    logic               out_take;

    always_comb
    begin
        sum_w      = {1'b0, req_size} + (REQ_W + 1)'(HDR_BYTES - 1);
        rnd_w      = {sum_w[REQ_W:3], 3'b000};
        rnd_min_w  = (rnd_w < (REQ_W + 1)'(MIN_CHUNK)) ? (REQ_W + 1)'(MIN_CHUNK) : rnd_w;
        oversize_w = ({1'b0, rnd_min_w} + (REQ_W + 2)'(HDR_BYTES))
                     > (REQ_W + 2)'(HEAP_BYTES);
    end

    always_comb
    begin
        end_w     = {1'b0, bump_reg} + (BUMP_W + 1)'(HDR_BYTES) + {1'b0, sz_reg};
        pay_w     = {1'b0, bump_reg} + (BUMP_W + 1)'(HDR_BYTES);
        bump_fail = (32'(end_w) > 32'(HEAP_BYTES)) || (32'(pay_w) > 32'(OFF_MAX));
    end

    assign table_full = count_reg >= CNT_W'(FREE_SLOTS);
    assign out_take   = out_valid_reg && !rsp_stall;

    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = j_reg;
        tbl_wdata = rdata_reg;
        if (cmd.sh_wr)
        begin
            tbl_we = 1'b1;
        end
        else if (cmd.push && !table_full)
        begin
            tbl_we           = 1'b1;
            tbl_waddr        = count_reg[SLOT_AW-1:0];
            tbl_wdata.offset = off_reg;
            tbl_wdata.size   = hdr_ok_reg ? hdr_rdata_reg : '0;
        end
        tbl_re    = cmd.scan_rd || cmd.sh_rd;
        tbl_raddr = cmd.sh_rd ? (j_reg + SLOT_AW'(1)) : scan_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            table_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            rdata_reg <= table_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bump && !bump_fail)
        begin
            hdr_mem[bump_reg[HDR_AW+2:3]] <= sz_reg;
        end
        if (cmd.hdr_rd)
        begin
            hdr_rdata_reg <= hdr_mem[hdr_index(off_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.bump && !bump_fail)
            begin
                bump_reg <= end_w[BUMP_W-1:0];
            end
            if (cmd.pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.push && !table_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            is_free_reg  <= req_type;
            oversize_reg <= oversize_w;
            sz_reg       <= rnd_min_w[SIZE_W-1:0];
            off_reg      <= free_offset;
        end
        if (cmd.hdr_rd)
        begin
            hdr_ok_reg <= hdr_in_range(off_reg);
        end
        if (cmd.scan_init)
        begin
            scan_reg <= SLOT_AW'(count_reg - CNT_W'(1));
        end
        else if (cmd.scan_dec)
        begin
            scan_reg <= scan_reg - SLOT_AW'(1);
        end
        if (cmd.take_match)
        begin
            j_reg       <= scan_reg;
            res_pay_reg <= rdata_reg.offset;
        end
        else if (cmd.sh_wr)
        begin
            j_reg <= j_reg + SLOT_AW'(1);
        end
        if (cmd.pop)
        begin
            res_code_reg <= RES_REUSED;
        end
        if (cmd.set_no_space)
        begin
            res_code_reg <= RES_NO_SPACE;
            res_pay_reg  <= '0;
        end
        if (cmd.bump)
        begin
            if (bump_fail)
            begin
                res_code_reg <= RES_NO_SPACE;
                res_pay_reg  <= '0;
            end
            else
            begin
                res_code_reg <= RES_NEW;
                res_pay_reg  <= pay_w[OFF_W-1:0];
            end
        end
        if (cmd.push)
        begin
            res_code_reg <= table_full ? RES_TABLE_FULL : RES_FREED;
            res_pay_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            out_code_reg <= res_code_reg;
            out_pay_reg  <= res_pay_reg;
        end
    end

    always_comb
    begin
        st.is_free    = is_free_reg;
        st.oversize   = oversize_reg;
        st.cnt_zero   = count_reg == '0;
        st.match      = rdata_reg.size == sz_reg;
        st.scan_zero  = scan_reg == '0;
        st.match_last = (CNT_W'(scan_reg) + CNT_W'(1)) >= count_reg;
        st.sh_last    = (CNT_W'(j_reg) + CNT_W'(2)) >= count_reg;
        st.out_free   = !out_valid_reg || !rsp_stall;
    end

    assign rsp_valid      = out_valid_reg;
    assign status         = out_code_reg;
    assign payload_offset = out_pay_reg;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the bump allocator with exact-fit list
// A directed opening covers size rounding, the oversize and heap-exhausted
// refusals, reuse from the top, middle and bottom of the free table, double
// frees and frees at unaligned offsets. Random traffic follows, alternating
// between free-heavy and reuse-heavy stretches so that the free table fills
// and drains and the heap runs out. Every accepted item is fed to a
// scoreboard that predicts the result, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import bafl_pkg::*;

    localparam bit REQ_ALLOC = 1'b0;
    localparam bit REQ_FREE  = 1'b1;
    localparam int N_RANDOM  = 1800;

    class heap_scoreboard;
        int unsigned      bump_top;
        int unsigned      free_count;
        logic [OFF_W-1:0] slot_off [FREE_SLOTS];
        int unsigned      slot_size [FREE_SLOTS];
        int unsigned      hdr_len [HDR_DEPTH];
        int unsigned      hdr_written [$];
        res_code_t        exp_status [$];
        logic [OFF_W-1:0] exp_offset [$];
        int               errors;

        function void push_result(res_code_t st, logic [OFF_W-1:0] off);
            exp_status.push_back(st);
            exp_offset.push_back(off);
        endfunction

        function void note_request(bit rtype, logic [REQ_W-1:0] rsize,
                                   logic [OFF_W-1:0] foff);
            longint unsigned  chunk;
            longint unsigned  top_end;
            logic [OFF_W-1:0] base;
            int unsigned      idx;
            int               k;
            int               j;
            if (rtype == REQ_FREE) begin
                base = foff - OFF_W'(HDR_BYTES);
                idx  = base >> 3;
                if (free_count >= FREE_SLOTS) begin
                    push_result(RES_TABLE_FULL, '0);
                end
                else begin
                    slot_off[free_count]  = foff;
                    slot_size[free_count] = (idx < HDR_DEPTH) ? hdr_len[idx] : 0;
                    free_count++;
                    push_result(RES_FREED, '0);
                end
                return;
            end
            chunk = (64'(rsize) + 64'd7) & ~64'd7;
            if (chunk < MIN_CHUNK)
                chunk = MIN_CHUNK;
            if (chunk + HDR_BYTES > HEAP_BYTES) begin
                push_result(RES_NO_SPACE, '0);
                return;
            end
            for (k = int'(free_count) - 1; k >= 0; k--) begin
                if (slot_size[k] == chunk) begin
                    push_result(RES_REUSED, slot_off[k]);
                    for (j = k; j + 1 < int'(free_count); j++) begin
                        slot_off[j]  = slot_off[j + 1];
                        slot_size[j] = slot_size[j + 1];
                    end
                    free_count--;
                    return;
                end
            end
            top_end = bump_top + HDR_BYTES + chunk;
            if (top_end > HEAP_BYTES || bump_top + HDR_BYTES > OFF_MAX) begin
                push_result(RES_NO_SPACE, '0);
                return;
            end
            if ((bump_top >> 3) < HDR_DEPTH) begin
                hdr_len[bump_top >> 3] = int'(chunk);
                hdr_written.push_back(bump_top >> 3);
            end
            push_result(RES_NEW, OFF_W'(bump_top + HDR_BYTES));
            bump_top = int'(top_end);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [OFF_W-1:0] off);
            res_code_t        es;
            logic [OFF_W-1:0] eo;
            if (exp_status.size() == 0) begin
                $error("unexpected result: status %0d, payload_offset %0d", st, off);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            eo = exp_offset.pop_front();
            if (st !== es) begin
                $error("status: expected %0d, actual %0d", es, st);
                errors++;
            end
            if (off !== eo) begin
                $error("payload_offset: expected %0d, actual %0d", eo, off);
                errors++;
            end
        endfunction

        function int pending();
            return exp_status.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic                req_type;
    logic [REQ_W-1:0]    req_size;
    logic [OFF_W-1:0]    free_offset;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    payload_offset;

    heap_scoreboard sb;
    bit             calm;
    int             free_pct;

    bump_allocator_exact_fit_free_list_core u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .req_size       (req_size),
        .free_offset    (free_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .payload_offset (payload_offset)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(status, payload_offset);
        rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
    end

    task automatic send_item(bit t, logic [REQ_W-1:0] sz, logic [OFF_W-1:0] off);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= t;
        req_size    <= sz;
        free_offset <= off;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(t, sz, off);
    endtask

    // Frees only target chunks whose size header has been written; a few use
    // unaligned offsets that still map onto the same header.
    function automatic void next_random_item(output bit t, output logic [REQ_W-1:0] sz,
                                             output logic [OFF_W-1:0] off);
        int          c;
        int unsigned w;
        int unsigned k;
        sz  = $urandom();
        off = OFF_W'($urandom());
        if (sb.hdr_written.size() > 0 && $urandom_range(0, 99) < free_pct) begin
            t   = REQ_FREE;
            w   = sb.hdr_written[$urandom_range(0, sb.hdr_written.size() - 1)];
            off = OFF_W'(w * 8 + HDR_BYTES
                         + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 0));
            return;
        end
        t = REQ_ALLOC;
        c = $urandom_range(0, 99);
        if (c < 45 && sb.free_count > 0) begin
            k  = $urandom_range(0, sb.free_count - 1);
            sz = sb.slot_size[k] - $urandom_range(0, 7);
        end
        else if (c < 82)
            sz = $urandom_range(0, 200);
        else if (c < 95)
            sz = $urandom_range(201, 1024);
        else if (c < 97)
            sz = $urandom_range(1025, 16384);
        else
            sz = $urandom();
    endfunction

    initial
    begin
        bit               t;
        logic [REQ_W-1:0] sz;
        logic [OFF_W-1:0] off;
        sb          = new();
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = REQ_ALLOC;
        req_size    = '0;
        free_offset = '0;
        calm        = 1'b0;
        free_pct    = 45;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(REQ_ALLOC, 32'd0, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd1, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd24, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd25, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd65529, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'hFFFF_FFFF, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd65520, OFF_W'($urandom()));
        send_item(REQ_FREE, $urandom(), 16'd8);
        send_item(REQ_FREE, $urandom(), 16'd40);
        send_item(REQ_FREE, $urandom(), 16'd104);
        send_item(REQ_FREE, $urandom(), 16'd8);
        send_item(REQ_FREE, $urandom(), 16'd43);
        send_item(REQ_ALLOC, 32'd20, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd32, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd17, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd24, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd24, OFF_W'($urandom()));
        send_item(REQ_ALLOC, 32'd24, OFF_W'($urandom()));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 900 && i < 1100);
            if (i % 400 < 100)
                free_pct = 70;
            else if (i % 400 < 200)
                free_pct = 20;
            else
                free_pct = 45;
            next_random_item(t, sz, off);
            send_item(t, sz, off);
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
